/* hdl/bmm_pkg.sv */
// shared types, codes and constants of the banked data memory map
package bmm_pkg;

	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;

	localparam int MAIN_BYTES_DEF = 1024;
	localparam int WORK_BYTES_DEF = 512;
	localparam int XRAM_BYTES_DEF = 124;
	localparam int XRAM_BANKS = 3;

	// operation codes
	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_RAW_RD = 3'd2;
	localparam logic [2:0] OP_RAW_WR = 3'd3;
	localparam logic [2:0] OP_PUSH   = 3'd4;
	localparam logic [2:0] OP_POP    = 3'd5;
	localparam logic [2:0] OP_XREAD  = 3'd6;

	// access targets
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_MAIN = 3'd1;
	localparam logic [2:0] TGT_WORK = 3'd2;
	localparam logic [2:0] TGT_XRAM = 3'd3;
	localparam logic [2:0] TGT_SPEC = 3'd4;

	// special register selects
	localparam logic [2:0] SPR_PSW    = 3'd0;
	localparam logic [2:0] SPR_SP     = 3'd1;
	localparam logic [2:0] SPR_STAD   = 3'd2;
	localparam logic [2:0] SPR_XBNK   = 3'd3;
	localparam logic [2:0] SPR_VSEL   = 3'd4;
	localparam logic [2:0] SPR_VRMAD1 = 3'd5;
	localparam logic [2:0] SPR_VRMAD2 = 3'd6;
	localparam logic [2:0] SPR_NONE   = 3'd7;

	localparam logic [ADDR_W-1:0] ADR_PSW    = 10'h101;
	localparam logic [ADDR_W-1:0] ADR_SP     = 10'h106;
	localparam logic [ADDR_W-1:0] ADR_STAD   = 10'h122;
	localparam logic [ADDR_W-1:0] ADR_XBNK   = 10'h125;
	localparam logic [ADDR_W-1:0] ADR_VSEL   = 10'h163;
	localparam logic [ADDR_W-1:0] ADR_VRMAD1 = 10'h164;
	localparam logic [ADDR_W-1:0] ADR_VRMAD2 = 10'h165;
	localparam logic [ADDR_W-1:0] ADR_WIN    = 10'h166;
	localparam logic [ADDR_W-1:0] ADR_LOW_TOP = 10'h100;
	localparam logic [ADDR_W-1:0] ADR_XRAM_LO = 10'h180;
	localparam logic [ADDR_W-1:0] ADR_XRAM_HI = 10'h1FB;

	localparam int PSW_BANK_BIT = 1;
	localparam int VSEL_INC_BIT = 4;

	typedef struct packed {
		logic [1:0]        bank_select;
		logic [DATA_W-1:0] write_data;
		logic [ADDR_W-1:0] address;
		logic [2:0]        operation;
	} item_t;

	typedef struct packed {
		logic [2:0]        tgt;
		logic              rd;
		logic              we;
		logic              fault;
		logic [ADDR_W-1:0] idx;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] spec;
	} req_t;

	function automatic logic [2:0] spr_code(input logic [ADDR_W-1:0] a);
		logic [2:0] c;
		case (a)
			ADR_PSW:    c = SPR_PSW;
			ADR_SP:     c = SPR_SP;
			ADR_STAD:   c = SPR_STAD;
			ADR_XBNK:   c = SPR_XBNK;
			ADR_VSEL:   c = SPR_VSEL;
			ADR_VRMAD1: c = SPR_VRMAD1;
			ADR_VRMAD2: c = SPR_VRMAD2;
			default:    c = SPR_NONE;
		endcase
		return c;
	endfunction

endpackage

/* hdl/banked_data_memory_map.sv */
// a word accepted is registered in decode, read into the stage-two registers, then held in the output register
// a new word is taken only once the last one has left decode and stage two is free or moving on
// the special registers sit in flops, so each access touches at most one ram port
// a result word waits in the output register while the next word is decoded
// reset clears the handshake state and the special registers; rams are not cleared
module banked_data_memory_map #(
	parameter int MAIN_BYTES = bmm_pkg::MAIN_BYTES_DEF,
	parameter int WORK_BYTES = bmm_pkg::WORK_BYTES_DEF,
	parameter int XRAM_BYTES = bmm_pkg::XRAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], address[12:3], write_data[20:13], bank_select[22:21], zero pad
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], range_fault[8], zero pad
	output logic [15:0] m_axis_tdata
);

	localparam int MAW = $clog2(MAIN_BYTES);
	localparam int WAW = $clog2(WORK_BYTES);
	localparam int XAW = $clog2(bmm_pkg::XRAM_BANKS * XRAM_BYTES);

	logic          accept;
	logic          s1_v;
	bmm_pkg::req_t req_s1;
	bmm_pkg::item_t item;

	logic       s2_v, s2_move;
	logic [2:0] tgt_s2;
	logic       rd_s2, fault_s2;
	logic [7:0] spec_s2;

	logic [7:0] main_rd, work_rd, xram_rd, rd_val;
	logic       out_v_q;
	logic [7:0] out_data_q;
	logic       out_fault_q;

	assign item    = bmm_pkg::item_t'(s_axis_tdata[22:0]);
	assign s2_move = s2_v && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !s1_v && (!s2_v || s2_move);
	assign accept  = s_axis_tvalid && s_axis_tready;

	bmm_decode #(
		.MAIN_BYTES(MAIN_BYTES),
		.WORK_BYTES(WORK_BYTES),
		.XRAM_BYTES(XRAM_BYTES)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.s1_v   (s1_v),
		.req_s1 (req_s1)
	);

	bmm_ram #(.DEPTH(MAIN_BYTES), .WIDTH(8)) u_main (
		.clk   (clk),
		.en    (s1_v && req_s1.tgt == bmm_pkg::TGT_MAIN),
		.we    (req_s1.we),
		.addr  (MAW'(req_s1.idx)),
		.wdata (req_s1.wdata),
		.rdata (main_rd)
	);

	bmm_ram #(.DEPTH(WORK_BYTES), .WIDTH(8)) u_work (
		.clk   (clk),
		.en    (s1_v && req_s1.tgt == bmm_pkg::TGT_WORK),
		.we    (req_s1.we),
		.addr  (WAW'(req_s1.idx)),
		.wdata (req_s1.wdata),
		.rdata (work_rd)
	);

	bmm_ram #(.DEPTH(bmm_pkg::XRAM_BANKS * XRAM_BYTES), .WIDTH(8)) u_xram (
		.clk   (clk),
		.en    (s1_v && req_s1.tgt == bmm_pkg::TGT_XRAM),
		.we    (req_s1.we),
		.addr  (XAW'(req_s1.idx)),
		.wdata (req_s1.wdata),
		.rdata (xram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_v) begin
			s2_v <= 1'b1;
		end else if (s2_move) begin
			s2_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v) begin
			tgt_s2   <= req_s1.tgt;
			rd_s2    <= req_s1.rd;
			fault_s2 <= req_s1.fault;
			spec_s2  <= req_s1.spec;
		end
	end

	// ram read data holds until the word moves on, no later access is issued
	always_comb begin
		case (tgt_s2)
			bmm_pkg::TGT_MAIN: rd_val = main_rd;
			bmm_pkg::TGT_WORK: rd_val = work_rd;
			bmm_pkg::TGT_XRAM: rd_val = xram_rd;
			bmm_pkg::TGT_SPEC: rd_val = spec_s2;
			default:           rd_val = 8'd0;
		endcase
		if (!rd_s2) begin
			rd_val = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_move) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_data_q  <= rd_val;
			out_fault_q <= fault_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_fault_q, out_data_q};

endmodule

/* hdl/bmm_ram.sv */
// single-port synchronous ram with registered read data
module bmm_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* hdl/bmm_decode.sv */
// special registers and address decode of one access into a memory request
module bmm_decode #(
	parameter int MAIN_BYTES = bmm_pkg::MAIN_BYTES_DEF,
	parameter int WORK_BYTES = bmm_pkg::WORK_BYTES_DEF,
	parameter int XRAM_BYTES = bmm_pkg::XRAM_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  bmm_pkg::item_t item,
	output logic           s1_v,
	output bmm_pkg::req_t  req_s1
);

	localparam int XAW = $clog2(bmm_pkg::XRAM_BANKS * XRAM_BYTES);
	localparam int WAW = $clog2(WORK_BYTES);

	logic [7:0] psw_q, sp_q, stad_q, xbnk_q, vsel_q, vrmad1_q, vrmad2_q;

	bmm_pkg::req_t nxt;
	logic          use_main, use_xram, use_win;
	logic [9:0]    m_idx;
	logic [2:0]    sel;
	logic          spec_we;
	logic          sp_upd, win_upd;
	logic [7:0]    sp_nxt;
	logic [1:0]    x_bank;
	logic [10:0]   x_sum, x_off;
	logic          x_ok;
	logic [XAW-1:0] x_pos;
	logic [8:0]    w_ptr, w_nxt;
	logic [7:0]    spec_val;

	always_comb begin
		case (sel)
			bmm_pkg::SPR_PSW:    spec_val = psw_q;
			bmm_pkg::SPR_SP:     spec_val = sp_q;
			bmm_pkg::SPR_STAD:   spec_val = stad_q;
			bmm_pkg::SPR_XBNK:   spec_val = xbnk_q;
			bmm_pkg::SPR_VSEL:   spec_val = vsel_q;
			bmm_pkg::SPR_VRMAD1: spec_val = vrmad1_q;
			bmm_pkg::SPR_VRMAD2: spec_val = vrmad2_q;
			default:             spec_val = 8'd0;
		endcase
	end

	always_comb begin
		use_main = 1'b0;
		use_xram = 1'b0;
		use_win  = 1'b0;
		m_idx    = item.address;
		sp_upd   = 1'b0;
		sp_nxt   = sp_q;
		x_bank   = (xbnk_q > 8'd2) ? 2'd0 : xbnk_q[1:0];
		case (item.operation)
			bmm_pkg::OP_READ, bmm_pkg::OP_WRITE: begin
				if (item.address >= bmm_pkg::ADR_XRAM_LO &&
					item.address <= bmm_pkg::ADR_XRAM_HI) begin
					use_xram = 1'b1;
				end else if (item.address == bmm_pkg::ADR_WIN) begin
					use_win = 1'b1;
				end else begin
					use_main = 1'b1;
					// low page moves up by 512 when the bank bit is set
					if (item.address < bmm_pkg::ADR_LOW_TOP && psw_q[bmm_pkg::PSW_BANK_BIT]) begin
						m_idx = {2'b10, item.address[7:0]};
					end
				end
			end
			bmm_pkg::OP_RAW_RD, bmm_pkg::OP_RAW_WR: begin
				use_main = 1'b1;
			end
			bmm_pkg::OP_PUSH: begin
				use_main = 1'b1;
				sp_upd   = 1'b1;
				sp_nxt   = sp_q + 8'd1;
				m_idx    = {2'b00, sp_nxt};
			end
			bmm_pkg::OP_POP: begin
				use_main = 1'b1;
				sp_upd   = 1'b1;
				sp_nxt   = sp_q - 8'd1;
				// old stack top as a 9-bit value, so an empty stack reads 0x100
				m_idx    = {1'b0, {1'b0, sp_nxt} + 9'd1};
			end
			bmm_pkg::OP_XREAD: begin
				use_xram = 1'b1;
				x_bank   = (item.bank_select == 2'd3) ? 2'd0 : item.bank_select;
			end
			default: begin
			end
		endcase
	end

	assign x_sum = {1'b0, item.address} + {3'b000, stad_q};
	assign x_off = x_sum - {1'b0, bmm_pkg::ADR_XRAM_LO};
	assign x_ok  = (x_sum >= {1'b0, bmm_pkg::ADR_XRAM_LO}) && (x_off < 11'(XRAM_BYTES));
	assign x_pos = XAW'(x_bank) * XAW'(XRAM_BYTES) + XAW'(x_off);

	assign w_ptr = {vrmad2_q[0], vrmad1_q};
	assign w_nxt = w_ptr + 9'd1;
	assign sel   = bmm_pkg::spr_code(m_idx);

	always_comb begin
		nxt       = '0;
		nxt.tgt   = bmm_pkg::TGT_NONE;
		nxt.rd    = item.operation inside {bmm_pkg::OP_READ, bmm_pkg::OP_RAW_RD,
			bmm_pkg::OP_POP, bmm_pkg::OP_XREAD};
		nxt.we    = item.operation inside {bmm_pkg::OP_WRITE, bmm_pkg::OP_RAW_WR,
			bmm_pkg::OP_PUSH};
		nxt.wdata = item.write_data;
		spec_we   = 1'b0;
		win_upd   = 1'b0;
		if (use_main) begin
			if (sel != bmm_pkg::SPR_NONE) begin
				nxt.tgt  = bmm_pkg::TGT_SPEC;
				nxt.spec = spec_val;
				spec_we  = nxt.we;
			end else if ({1'b0, m_idx} < 11'(MAIN_BYTES)) begin
				nxt.tgt = bmm_pkg::TGT_MAIN;
				nxt.idx = m_idx;
			end
		end
		if (use_xram) begin
			if (x_ok) begin
				nxt.tgt = bmm_pkg::TGT_XRAM;
				nxt.idx = 10'(x_pos);
			end else begin
				nxt.fault = 1'b1;
			end
		end
		if (use_win) begin
			nxt.tgt = bmm_pkg::TGT_WORK;
			nxt.idx = 10'(w_ptr[WAW-1:0]);
			win_upd = vsel_q[bmm_pkg::VSEL_INC_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v     <= 1'b0;
			psw_q    <= 8'd0;
			sp_q     <= 8'd0;
			stad_q   <= 8'd0;
			xbnk_q   <= 8'd0;
			vsel_q   <= 8'd0;
			vrmad1_q <= 8'd0;
			vrmad2_q <= 8'd0;
		end else begin
			s1_v <= accept;
			if (accept) begin
				if (spec_we) begin
					case (sel)
						bmm_pkg::SPR_PSW:    psw_q    <= item.write_data;
						bmm_pkg::SPR_SP:     sp_q     <= item.write_data;
						bmm_pkg::SPR_STAD:   stad_q   <= item.write_data;
						bmm_pkg::SPR_XBNK:   xbnk_q   <= item.write_data;
						bmm_pkg::SPR_VSEL:   vsel_q   <= item.write_data;
						bmm_pkg::SPR_VRMAD1: vrmad1_q <= item.write_data;
						bmm_pkg::SPR_VRMAD2: vrmad2_q <= item.write_data;
						default: begin
						end
					endcase
				end
				if (sp_upd) begin
					sp_q <= sp_nxt;
				end
				// window pointer advances, only bit 0 kept in the high byte
				if (win_upd) begin
					vrmad1_q <= w_nxt[7:0];
					vrmad2_q <= {7'd0, w_nxt[8]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= nxt;
		end
	end

endmodule

/* hdl/bmm_checker.sv */
// port-level checks of the banked data memory map and their bind
module bmm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// checked at the following edge, so flops not yet reset at the first edge are not sampled
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result word valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result word changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word taken while one is still in decode");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("faulted access returned data");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
		else $error("result pad bits not zero");

endmodule

bind banked_data_memory_map bmm_checker u_bmm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
